### src/smbpec_pkg.sv
`default_nettype none

package smbpec_pkg;

  localparam int unsigned ADDR_W = 7;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned REG_ADDR_W = 24;

  localparam logic [BYTE_W-1:0] CRC_POLY = 8'h07;
  localparam logic [BYTE_W-1:0] CRC_INIT = 8'h00;

  localparam logic [ADDR_W-1:0] DEVICE_ADDRESS_RESET = 7'd1;
  localparam logic [BYTE_W-1:0] PAYLOAD_LEN_RESET = 8'd4;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_BYTE  = 1'b1
  } kind_t;

  typedef enum logic {
    CFG_DEVICE_ADDRESS = 1'b0,
    CFG_PAYLOAD_LEN    = 1'b1
  } cfg_index_t;

  typedef struct packed {
    kind_t                 kind;
    logic [REG_ADDR_W-1:0] register_address;
    logic [BYTE_W-1:0]     rx_byte;
  } request_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              check_done;
    logic              pec_match;
  } result_t;

  typedef struct packed {
    logic [ADDR_W-1:0] device_address;
    logic [BYTE_W-1:0] payload_len;
  } cfg_t;

  function automatic logic [BYTE_W-1:0] crc8_fold(input logic [BYTE_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] data);
    logic [BYTE_W-1:0] v;
    v = crc ^ data;
    for (int i = 0; i < BYTE_W; i++) begin
      if (v[BYTE_W-1]) begin
        v = {v[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[BYTE_W-2:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

`default_nettype wire

### src/smbus_read_pec_checker.sv
// channel | dir | tdata (low bit up)                    | tuser     | tlast
// s_axis  | in  | register_address[23:0], rx_byte[31:24] | kind      | -
// m_axis  | out | data_byte[7:0]                         | pec_match | check_done
// cfg     | in  | index 0 device_address, 1 payload_len  | -         | -
// one request a cycle unless stalled, via the input register, then the result register
// requests with no result (start, idle bytes) leave without waiting on m_axis
// a full result register blocks only a request that makes a result
// synchronous reset clears crc, byte count, transaction flag and both valids
`default_nettype none

module smbus_read_pec_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // register_address, rx_byte
  input  wire logic        s_axis_tuser,   // kind
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // data_byte
  output logic             m_axis_tuser,   // pec_match
  output logic             m_axis_tlast,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data
);

  smbpec_pkg::cfg_t     cfg;
  smbpec_pkg::request_t req;
  smbpec_pkg::result_t  result;
  smbpec_pkg::result_t  out_result;
  logic                 req_valid;
  logic                 has_result;
  logic                 fire;
  logic                 out_free;

  smbpec_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (smbpec_pkg::cfg_index_t'(cfg_index)),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  smbpec_check_stage u_check (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .req        (req),
    .cfg        (cfg),
    .has_result (has_result),
    .result     (result)
  );

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign fire          = req_valid && (!has_result || out_free);
  assign s_axis_tready = !req_valid || fire;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (s_axis_tready) begin
      req_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      req.kind             <= smbpec_pkg::kind_t'(s_axis_tuser);
      req.register_address <= s_axis_tdata[23:0];
      req.rx_byte          <= s_axis_tdata[31:24];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (fire && has_result) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && has_result) begin
      out_result <= result;
    end
  end

  assign m_axis_tdata = out_result.data_byte;
  assign m_axis_tlast = out_result.check_done;
  assign m_axis_tuser = out_result.pec_match;

  a_verdict_no_data: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata == 8'h00)
    else $error("verdict carries data");

  a_match_only_on_verdict: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> !m_axis_tuser)
    else $error("pec_match set on data byte");

  a_stalled_request_kept: assert property (@(posedge clk) disable iff (rst)
    req_valid && !fire |=> req_valid && $stable(req))
    else $error("stalled request lost");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(out_result))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

### src/smbpec_cfg_regs.sv
`default_nettype none

module smbpec_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire smbpec_pkg::cfg_index_t         cfg_index,
  input  wire logic [smbpec_pkg::BYTE_W-1:0]  cfg_data,
  output smbpec_pkg::cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.device_address <= smbpec_pkg::DEVICE_ADDRESS_RESET;
      cfg.payload_len    <= smbpec_pkg::PAYLOAD_LEN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        smbpec_pkg::CFG_DEVICE_ADDRESS: begin
          cfg.device_address <= cfg_data[smbpec_pkg::ADDR_W-1:0];
        end
        smbpec_pkg::CFG_PAYLOAD_LEN: begin
          cfg.payload_len <= cfg_data;
        end
        default: begin
          cfg <= cfg;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### src/smbpec_check_stage.sv
`default_nettype none

module smbpec_check_stage (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 fire,
  input  wire smbpec_pkg::request_t req,
  input  wire smbpec_pkg::cfg_t     cfg,
  output logic                      has_result,
  output smbpec_pkg::result_t       result
);

  logic [smbpec_pkg::BYTE_W-1:0] crc_accum;
  logic [smbpec_pkg::BYTE_W-1:0] crc_accum_next;
  logic [smbpec_pkg::BYTE_W-1:0] bytes_seen;
  logic [smbpec_pkg::BYTE_W-1:0] bytes_seen_next;
  logic                          in_transaction;
  logic                          in_transaction_next;
  logic [smbpec_pkg::BYTE_W-1:0] addr_w;
  logic [smbpec_pkg::BYTE_W-1:0] seed;

  assign addr_w = {cfg.device_address, 1'b0};

  always_comb begin
    seed = smbpec_pkg::crc8_fold(smbpec_pkg::CRC_INIT, addr_w);
    seed = smbpec_pkg::crc8_fold(seed, req.register_address[23:16]);
    seed = smbpec_pkg::crc8_fold(seed, req.register_address[15:8]);
    seed = smbpec_pkg::crc8_fold(seed, req.register_address[7:0]);
    seed = smbpec_pkg::crc8_fold(seed, addr_w | 8'h01);
  end

  always_comb begin
    crc_accum_next      = crc_accum;
    bytes_seen_next     = bytes_seen;
    in_transaction_next = in_transaction;
    has_result          = 1'b0;
    result              = '0;
    if (req.kind == smbpec_pkg::KIND_START) begin
      crc_accum_next      = seed;
      bytes_seen_next     = '0;
      in_transaction_next = 1'b1;
    end else if (in_transaction) begin
      has_result = 1'b1;
      if (bytes_seen < cfg.payload_len) begin
        crc_accum_next   = smbpec_pkg::crc8_fold(crc_accum, req.rx_byte);
        bytes_seen_next  = bytes_seen + 8'd1;
        result.data_byte = req.rx_byte;
      end else begin
        result.check_done   = 1'b1;
        result.pec_match    = (req.rx_byte == crc_accum);
        in_transaction_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_accum      <= smbpec_pkg::CRC_INIT;
      bytes_seen     <= '0;
      in_transaction <= 1'b0;
    end else if (fire) begin
      crc_accum      <= crc_accum_next;
      bytes_seen     <= bytes_seen_next;
      in_transaction <= in_transaction_next;
    end
  end

endmodule

`default_nettype wire

### verif/pec_result_checker.sv
`timescale 1ns / 100ps

package pec_tb_pkg;

  // bit-serial crc-8, message bits taken most significant first
  function automatic logic [7:0] pec_fold(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] r;
    logic       fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[7] ^ data[i];
      r  = {r[6:0], 1'b0} ^ (fb ? smbpec_pkg::CRC_POLY : 8'h00);
    end
    return r;
  endfunction

endpackage

module pec_result_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,
  input  wire logic        s_axis_tuser,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [7:0]  m_axis_tdata,
  input  wire logic        m_axis_tuser,
  input  wire logic        m_axis_tlast,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data,
  output int               pending,
  output int               failures
);

  logic [smbpec_pkg::ADDR_W-1:0] dev_addr;
  logic [smbpec_pkg::BYTE_W-1:0] read_len;
  logic [smbpec_pkg::BYTE_W-1:0] run_crc;
  logic [smbpec_pkg::BYTE_W-1:0] data_count;
  logic                          in_read;
  smbpec_pkg::result_t           predicted_out[$];
  int                            errs = 0;

  always @(posedge clk) begin : track
    smbpec_pkg::result_t           want;
    smbpec_pkg::result_t           res;
    logic [smbpec_pkg::BYTE_W-1:0] wr;
    logic [smbpec_pkg::BYTE_W-1:0] c;
    logic [smbpec_pkg::BYTE_W-1:0] rx;
    if (rst) begin
      dev_addr   = smbpec_pkg::DEVICE_ADDRESS_RESET;
      read_len   = smbpec_pkg::PAYLOAD_LEN_RESET;
      run_crc    = smbpec_pkg::CRC_INIT;
      data_count = '0;
      in_read    = 1'b0;
      predicted_out.delete();
    end else begin
      // results leaving the block
      if (m_axis_tvalid && m_axis_tready) begin
        if (predicted_out.size() == 0) begin
          $error("unexpected result: data_byte %02h check_done %0b pec_match %0b",
                 m_axis_tdata, m_axis_tlast, m_axis_tuser);
          errs++;
        end else begin
          want = predicted_out.pop_front();
          if (m_axis_tdata !== want.data_byte) begin
            $error("data_byte expected %02h actual %02h", want.data_byte, m_axis_tdata);
            errs++;
          end
          if (m_axis_tlast !== want.check_done) begin
            $error("check_done expected %0b actual %0b", want.check_done, m_axis_tlast);
            errs++;
          end
          if (m_axis_tuser !== want.pec_match) begin
            $error("pec_match expected %0b actual %0b", want.pec_match, m_axis_tuser);
            errs++;
          end
        end
      end
      // requests entering the block
      if (s_axis_tvalid && s_axis_tready) begin
        rx = s_axis_tdata[31:24];
        if (smbpec_pkg::kind_t'(s_axis_tuser) == smbpec_pkg::KIND_START) begin
          wr = {dev_addr, 1'b0};
          c  = pec_tb_pkg::pec_fold(smbpec_pkg::CRC_INIT, wr);
          c  = pec_tb_pkg::pec_fold(c, s_axis_tdata[23:16]);
          c  = pec_tb_pkg::pec_fold(c, s_axis_tdata[15:8]);
          c  = pec_tb_pkg::pec_fold(c, s_axis_tdata[7:0]);
          c  = pec_tb_pkg::pec_fold(c, wr | 8'h01);
          run_crc    = c;
          data_count = '0;
          in_read    = 1'b1;
        end else if (in_read) begin
          if (data_count < read_len) begin
            run_crc        = pec_tb_pkg::pec_fold(run_crc, rx);
            data_count     = data_count + 8'd1;
            res.data_byte  = rx;
            res.check_done = 1'b0;
            res.pec_match  = 1'b0;
          end else begin
            res.data_byte  = '0;
            res.check_done = 1'b1;
            res.pec_match  = (rx == run_crc);
            in_read        = 1'b0;
          end
          predicted_out = {predicted_out, res};
        end
      end
      if (cfg_we) begin
        if (smbpec_pkg::cfg_index_t'(cfg_index) == smbpec_pkg::CFG_DEVICE_ADDRESS)
          dev_addr = cfg_data[smbpec_pkg::ADDR_W-1:0];
        else read_len = cfg_data;
      end
    end
    pending  <= predicted_out.size();
    failures <= errs;
  end

endmodule

### verif/smbus_read_pec_checker_test.sv
`timescale 1ns / 100ps

module smbus_read_pec_checker_test;

  typedef enum int {PEC_GOOD, PEC_BAD, PEC_NONE} pec_mode_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_we;
  logic        cfg_index;
  logic [7:0]  cfg_data;
  int          pending;
  int          failures;

  logic [smbpec_pkg::ADDR_W-1:0] cur_addr = smbpec_pkg::DEVICE_ADDRESS_RESET;
  logic [smbpec_pkg::BYTE_W-1:0] cur_len = smbpec_pkg::PAYLOAD_LEN_RESET;
  logic [smbpec_pkg::BYTE_W-1:0] frame_crc;
  int                            sent = 0;
  int                            tx_idle_pct = 0;
  int                            rx_idle_pct = 0;
  bit                            stall_go = 1'b0;

  always #4 clk = ~clk;

  smbus_read_pec_checker dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  pec_result_checker chk (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .pending       (pending),
    .failures      (failures)
  );

  // result side: random back-pressure, or one long hold-off on request
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_go) begin
        stall_go = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk);
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  task automatic push_request(input smbpec_pkg::kind_t k, input logic [23:0] ra,
                              input logic [7:0] rb);
    int gap;
    gap = 0;
    if ($urandom_range(0, 99) < tx_idle_pct) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {rb, ra};
    s_axis_tuser  <= k;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic send_frame(input logic [23:0] ra, input int n_data, input bit fixed,
                            input logic [7:0] fill, input pec_mode_t mode);
    logic [7:0] wr;
    logic [7:0] b;
    wr        = {cur_addr, 1'b0};
    frame_crc = pec_tb_pkg::pec_fold(smbpec_pkg::CRC_INIT, wr);
    frame_crc = pec_tb_pkg::pec_fold(frame_crc, ra[23:16]);
    frame_crc = pec_tb_pkg::pec_fold(frame_crc, ra[15:8]);
    frame_crc = pec_tb_pkg::pec_fold(frame_crc, ra[7:0]);
    frame_crc = pec_tb_pkg::pec_fold(frame_crc, wr | 8'h01);
    push_request(smbpec_pkg::KIND_START, ra, 8'($urandom));
    for (int i = 0; i < n_data; i++) begin
      b         = fixed ? fill : 8'($urandom);
      frame_crc = pec_tb_pkg::pec_fold(frame_crc, b);
      push_request(smbpec_pkg::KIND_BYTE, 24'($urandom), b);
    end
    if (mode == PEC_GOOD) push_request(smbpec_pkg::KIND_BYTE, 24'($urandom), frame_crc);
    else if (mode == PEC_BAD)
      push_request(smbpec_pkg::KIND_BYTE, 24'($urandom),
                   frame_crc ^ 8'($urandom_range(1, 255)));
    sent += n_data + 1 + (mode == PEC_NONE ? 0 : 1);
  endtask

  // drain all results, then give the pipeline time to empty
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input smbpec_pkg::cfg_index_t idx, input logic [7:0] val);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == smbpec_pkg::CFG_DEVICE_ADDRESS) cur_addr = val[smbpec_pkg::ADDR_W-1:0];
    else cur_len = val;
  endtask

  task automatic random_items(input int count);
    int first;
    int r;
    first = sent;
    while (sent - first < count) begin
      r = $urandom_range(0, 99);
      if (r < 70) send_frame(24'($urandom), int'(cur_len), 1'b0, 8'h00, PEC_GOOD);
      else if (r < 82) send_frame(24'($urandom), int'(cur_len), 1'b0, 8'h00, PEC_BAD);
      else if (r < 90)
        send_frame(24'($urandom), cur_len == 0 ? 0 : $urandom_range(0, cur_len - 1),
                   1'b0, 8'h00, PEC_NONE);
      else
        repeat ($urandom_range(1, 3))
          push_request(smbpec_pkg::KIND_BYTE, 24'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    int waited;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= smbpec_pkg::KIND_START;
    cfg_we        <= 1'b0;
    cfg_index     <= smbpec_pkg::CFG_DEVICE_ADDRESS;
    cfg_data      <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 12 : (phase == 1) ? 60 : 0;
      rx_idle_pct = (phase == 0) ? 60 : (phase == 1) ? 12 : 0;
      if (phase == 0) begin
        // byte while idle, then all-zero and all-one frames
        push_request(smbpec_pkg::KIND_BYTE, 24'hFFFFFF, 8'hFF);
        send_frame(24'h000000, 4, 1'b1, 8'h00, PEC_GOOD);
        send_frame(24'hFFFFFF, 4, 1'b1, 8'hFF, PEC_BAD);
        push_request(smbpec_pkg::KIND_BYTE, 24'h000000, 8'h00);
        // restart abandons a running read
        send_frame(24'($urandom), 2, 1'b0, 8'h00, PEC_NONE);
        send_frame(24'($urandom), 4, 1'b0, 8'h00, PEC_GOOD);
        // length shortened mid-read: next byte is the checksum
        send_frame(24'($urandom), 3, 1'b0, 8'h00, PEC_NONE);
        write_reg(smbpec_pkg::CFG_PAYLOAD_LEN, 8'd2);
        push_request(smbpec_pkg::KIND_BYTE, 24'($urandom), frame_crc);
        // address change mid-read leaves the running crc alone
        send_frame(24'($urandom), 2, 1'b0, 8'h00, PEC_NONE);
        write_reg(smbpec_pkg::CFG_DEVICE_ADDRESS, 8'hD5);
        push_request(smbpec_pkg::KIND_BYTE, 24'($urandom), frame_crc);
        // zero length and address extremes
        write_reg(smbpec_pkg::CFG_PAYLOAD_LEN, 8'd0);
        write_reg(smbpec_pkg::CFG_DEVICE_ADDRESS, 8'h00);
        send_frame(24'($urandom), 0, 1'b0, 8'h00, PEC_GOOD);
        send_frame(24'($urandom), 0, 1'b0, 8'h00, PEC_BAD);
        // longest read under a long result hold-off
        write_reg(smbpec_pkg::CFG_DEVICE_ADDRESS, 8'h7F);
        write_reg(smbpec_pkg::CFG_PAYLOAD_LEN, 8'd255);
        stall_go = 1'b1;
        send_frame(24'($urandom), 255, 1'b0, 8'h00, PEC_GOOD);
        settle();
      end
      for (int s = 0; s < 3; s++) begin
        write_reg(smbpec_pkg::CFG_DEVICE_ADDRESS, 8'($urandom));
        write_reg(smbpec_pkg::CFG_PAYLOAD_LEN, 8'($urandom_range(0, 8)));
        random_items(110);
      end
    end

    s_axis_tvalid <= 1'b0;
    waited = 0;
    while (pending != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end

endmodule

### smbus_read_pec_checker.f
src/smbpec_pkg.sv
src/smbpec_cfg_regs.sv
src/smbpec_check_stage.sv
src/smbus_read_pec_checker.sv
verif/pec_result_checker.sv
verif/smbus_read_pec_checker_test.sv
